>>> rtl/pqt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue table package
// Sizes, operation and status codes, controller states and the command and
// status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package pqt_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int PRI_W    = 32;
   localparam int OP_W     = 2;
   localparam int ST_W     = 2;
   localparam int ECNT_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH,
      OP_EXTRACT,
      OP_PEEK,
      OP_MODIFY
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK,
      ST_EMPTY,
      ST_FULL,
      ST_NOT_FOUND
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic shift_start;
      logic shift;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic req_is_push;
      logic queue_empty;
      logic is_extract;
      logic walk_done;
   } sts_type;

   // The reported entry count is the full true count; ECNT_W is wide enough to hold it.
   function automatic logic [ECNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+ECNT_W-1:0] wide;
      wide = {{ECNT_W{1'b0}}, c};
      return wide[ECNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/pqt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue table controller
// Sequences request capture, the table scan, compaction and the response.
// ----------------------------------------------------------------------------
module pqt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pqt_pkg::cmd_type cmd,
   input  pqt_pkg::sts_type sts
);
   import pqt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (sts.req_is_push || sts.queue_empty) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.walk_done) begin
               state_in = sts.is_extract ? S_SHIFT : S_FINISH;
            end
         end
         S_SHIFT: begin
            if (sts.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:   cmd.load = req_valid;
         S_SCAN: begin
            cmd.scan        = 1'b1;
            cmd.shift_start = sts.walk_done && sts.is_extract;
         end
         S_SHIFT:  cmd.shift = 1'b1;
         S_FINISH: cmd.commit = out_free;
         default:  cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/pqt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue table datapath
// Entry tables, entry count, scan comparator, compaction walk and the
// response registers.
// ----------------------------------------------------------------------------
module pqt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pqt_pkg::cmd_type                     cmd,
   output pqt_pkg::sts_type                     sts,
   input  logic        [pqt_pkg::OP_W-1:0]      req_operation,
   input  logic signed [pqt_pkg::VAL_W-1:0]     req_item_value,
   input  logic        [pqt_pkg::PRI_W-1:0]     req_item_priority,
   output logic signed [pqt_pkg::VAL_W-1:0]     rsp_result_value,
   output logic        [pqt_pkg::ST_W-1:0]      rsp_status,
   output logic        [pqt_pkg::ECNT_W-1:0]    rsp_entry_count
);
   import pqt_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [VAL_W-1:0] val_mem [CAPACITY];
   logic [PRI_W-1:0] pri_mem [CAPACITY];

   op_type           op_ff;
   logic [VAL_W-1:0] val_ff;
   logic [PRI_W-1:0] pri_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pipe_valid_ff, pipe_valid_in;
   logic [IDX_W-1:0] pipe_idx_ff;
   logic [VAL_W-1:0] rd_val_ff;
   logic [PRI_W-1:0] rd_pri_ff;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [PRI_W-1:0] best_pri_ff, best_pri_in;
   logic [VAL_W-1:0] best_val_ff, best_val_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic signed [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   status_type       rsp_st_ff, rsp_st_in;
   logic [ECNT_W-1:0] rsp_cnt_ff;

   logic             issue_active;
   logic             take;
   logic             full;
   logic             empty;
   logic             val_we, pri_we;
   logic [IDX_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_val;
   logic [PRI_W-1:0] wr_pri;

   assign full  = (count_ff == CAP_CNT);
   assign empty = (count_ff == '0);

   assign sts.req_is_push = (req_operation == OP_PUSH);
   assign sts.queue_empty = empty;
   assign sts.is_extract  = (op_ff == OP_EXTRACT);
   assign sts.walk_done   = (issue_ff >= count_ff) && !pipe_valid_ff;

   // One table read is issued per cycle while walking; its data returns through a read register.
   assign issue_active  = (cmd.scan || cmd.shift) && (issue_ff < count_ff);
   assign pipe_valid_in = issue_active;
   assign take          = cmd.scan && pipe_valid_ff;

   always_comb begin
      issue_in = issue_ff;
      if (cmd.load) begin
         issue_in = '0;
      end else if (cmd.shift_start) begin
         issue_in = CNT_W'(best_idx_ff) + CNT_W'(1);
      end else if (issue_active) begin
         issue_in = issue_ff + CNT_W'(1);
      end
   end

   // Entry zero always seeds the maximum; later entries win only when strictly higher.
   always_comb begin
      best_idx_in  = best_idx_ff;
      best_pri_in  = best_pri_ff;
      best_val_in  = best_val_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      if (cmd.load) begin
         found_in = 1'b0;
      end else if (take) begin
         if ((pipe_idx_ff == '0) || (rd_pri_ff > best_pri_ff)) begin
            best_idx_in = pipe_idx_ff;
            best_pri_in = rd_pri_ff;
            best_val_in = rd_val_ff;
         end
         if (!found_ff && (rd_val_ff == val_ff)) begin
            found_in     = 1'b1;
            found_idx_in = pipe_idx_ff;
         end
      end
   end

   always_comb begin
      val_we     = 1'b0;
      pri_we     = 1'b0;
      wr_addr    = pipe_idx_ff - IDX_W'(1);
      wr_val     = rd_val_ff;
      wr_pri     = rd_pri_ff;
      count_in   = count_ff;
      rsp_val_in = '0;
      rsp_st_in  = ST_OK;
      if (cmd.shift && pipe_valid_ff) begin
         val_we = 1'b1;
         pri_we = 1'b1;
      end else if (cmd.commit) begin
         if (op_ff == OP_PUSH) begin
            if (full) begin
               rsp_st_in = ST_FULL;
            end else begin
               val_we   = 1'b1;
               pri_we   = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_val   = val_ff;
               wr_pri   = pri_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end else if (empty) begin
            rsp_st_in = ST_EMPTY;
         end else begin
            case (op_ff)
               OP_EXTRACT: begin
                  rsp_val_in = best_val_ff;
                  count_in   = count_ff - CNT_W'(1);
               end
               OP_PEEK: rsp_val_in = best_val_ff;
               OP_MODIFY: begin
                  if (found_ff) begin
                     pri_we  = 1'b1;
                     wr_addr = found_idx_ff;
                     wr_pri  = pri_ff;
                  end else begin
                     rsp_st_in = ST_NOT_FOUND;
                  end
               end
               default: rsp_st_in = ST_OK;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
      if (pri_we) begin
         pri_mem[wr_addr] <= wr_pri;
      end
      rd_val_ff <= val_mem[issue_ff[IDX_W-1:0]];
      rd_pri_ff <= pri_mem[issue_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pipe_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_operation);
         val_ff <= req_item_value;
         pri_ff <= req_item_priority;
      end
      issue_ff     <= issue_in;
      pipe_idx_ff  <= issue_ff[IDX_W-1:0];
      best_idx_ff  <= best_idx_in;
      best_pri_ff  <= best_pri_in;
      best_val_ff  <= best_val_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      if (cmd.commit) begin
         rsp_val_ff <= rsp_val_in;
         rsp_st_ff  <= rsp_st_in;
         rsp_cnt_ff <= to_entry_count(count_in);
      end
   end

   assign rsp_result_value = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_entry_count  = rsp_cnt_ff;

endmodule
`default_nettype wire

>>> rtl/priority_queue_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue table unit
// Unsorted priority queue kept in arrival order: push, extract-max,
// peek-max and modify-priority, one request at a time.
//
// Requests arrive on req_valid/req_stall with the operation, value and
// priority; each request produces exactly one response on rsp_valid/rsp_stall
// carrying the result value, a status code and the entry count afterwards.
// The unit takes one request at a time and holds req_stall high from the
// cycle after acceptance until its response is loaded into the output
// register. A push, or any request on an empty table, goes straight to the
// finish state without a table walk. Peek and modify walk every stored entry
// through a single comparator, one table read per cycle, before they respond.
// Extract adds the compaction walk, which moves one entry per cycle from the
// maximum to the end of the table. When the receiver stalls, the response is
// held in the output register and a new request is taken, but its response
// waits for the register to free. Reset empties the table; the entry storage
// itself is not cleared.
// ----------------------------------------------------------------------------
module priority_queue_table_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic        [pqt_pkg::OP_W-1:0]      req_operation,
   input  logic signed [pqt_pkg::VAL_W-1:0]     req_item_value,
   input  logic        [pqt_pkg::PRI_W-1:0]     req_item_priority,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pqt_pkg::VAL_W-1:0]     rsp_result_value,
   output logic        [pqt_pkg::ST_W-1:0]      rsp_status,
   output logic        [pqt_pkg::ECNT_W-1:0]    rsp_entry_count
);
   import pqt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   pqt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule
`default_nettype wire
